// File: hdl/gshare_branch_predictor_btb_unit_assert.svh
// Assertion macros used by the branch predictor top level.
`ifndef GSHARE_BRANCH_PREDICTOR_BTB_UNIT_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_BTB_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define GBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define GBP_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GBP_ASSERT(lbl, prop, msg)
`define GBP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: hdl/gbp_pkg.sv
// Shared constants and types of the gshare predictor with target buffer.
package gbp_pkg;

    localparam int HIST_BITS = 8;
    localparam int IDX_BITS  = 10;
    localparam int PC_W      = 32;
    localparam int CLR_BITS  = (IDX_BITS > HIST_BITS) ? IDX_BITS : HIST_BITS;

    // request kinds
    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    // two-bit saturating counter limits
    localparam logic [1:0] CNT_MAX       = 2'd3;
    localparam logic [1:0] CNT_MIN       = 2'd0;
    localparam logic [1:0] CNT_TAKEN_MIN = 2'd2;

    typedef logic [HIST_BITS-1:0] cidx_t;
    typedef logic [IDX_BITS-1:0]  bidx_t;

    typedef struct packed {
        logic            vld;
        logic            cond;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
    } btb_entry_t;

    typedef struct packed {
        logic       en;
        bidx_t      idx;
        btb_entry_t entry;
    } btb_wr_t;

    typedef struct packed {
        logic  en;
        cidx_t idx;
    } pht_rd_t;

    typedef struct packed {
        logic       en;
        cidx_t      idx;
        logic [1:0] val;
    } pht_wr_t;

endpackage

// File: hdl/gshare_branch_predictor_btb_unit.sv
// A predict request passes through the working stage and the result register before it shows on m_axis.
// Throughput: one request per cycle, predict or update, while no clearing runs and no predict
// waits on a full result register; the counter read-modify-write is closed by the bypass register.
// Reset: asynchronous, active low; then a clearing pass runs over every entry of both memories
// with s_axis_tready low.
`include "gshare_branch_predictor_btb_unit_assert.svh"

// Top level: request decode, history, result register and memory clearing.
module gshare_branch_predictor_btb_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] pc, [32] is_branch, [33] is_conditional, [34] was_taken,
    // [66:35] target, [71:67] zero
    input  logic [71:0] s_axis_tdata,
    // [0] kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] hit_branch, [1] hit_conditional, [2] predict_taken,
    // [34:3] predict_target, [39:35] zero
    output logic [39:0] m_axis_tdata
);

    localparam int PW = gbp_pkg::PC_W;
    localparam int HB = gbp_pkg::HIST_BITS;
    localparam int IB = gbp_pkg::IDX_BITS;
    localparam int CB = gbp_pkg::CLR_BITS;

    // request fields
    logic          accept;
    logic          in_kind;
    logic [PW-1:0] in_pc;
    logic          in_is_branch;
    logic          in_is_cond;
    logic          in_was_taken;
    logic [PW-1:0] in_target;
    gbp_pkg::cidx_t in_cidx;

    // clearing pass
    logic          clr_reg;
    logic          clr_next;
    logic [CB-1:0] clr_cnt_reg;
    logic [CB-1:0] clr_cnt_next;

    // global history
    gbp_pkg::cidx_t hist_reg;
    gbp_pkg::cidx_t hist_next;

    // working stage
    logic           s1_vld_reg;
    logic           s1_vld_next;
    logic           s1_kind_reg;
    logic [PW-1:0]  s1_pc_reg;
    logic           s1_upd_cnt_reg;
    logic           s1_taken_reg;
    gbp_pkg::cidx_t s1_cidx_reg;
    logic           s1_adv;

    // result register
    logic          m_vld_reg;
    logic          m_vld_next;
    logic [39:0]   m_data_reg;
    logic          m_load;

    // memory ports
    gbp_pkg::btb_wr_t    btb_wr;
    gbp_pkg::btb_entry_t btb_entry;
    gbp_pkg::pht_rd_t    pht_rd;
    gbp_pkg::pht_wr_t    pht_wr;
    logic [1:0]          cnt;
    logic [1:0]          cnt_upd;

    // prediction
    logic          hit;
    logic          hit_cond;
    logic          pred_taken;
    logic [PW-1:0] pred_target;

    // request decode
    assign in_kind      = s_axis_tuser;
    assign in_pc        = s_axis_tdata[31:0];
    assign in_is_branch = s_axis_tdata[32];
    assign in_is_cond   = s_axis_tdata[33];
    assign in_was_taken = s_axis_tdata[34];
    assign in_target    = s_axis_tdata[66:35];
    assign in_cidx      = in_pc[HB+1:2] ^ hist_reg;

    // an update never waits; a predict waits for the result register
    assign s1_adv        = !s1_vld_reg || (s1_kind_reg == gbp_pkg::KIND_UPDATE)
                           || !m_vld_reg || m_axis_tready;
    assign s_axis_tready = !clr_reg && s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // clearing sweep after reset
    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {CB{1'b1}})
            begin
                clr_next = 1'b0;
            end
        end
    end

    // history shifts at acceptance of a conditional branch update
    always_comb
    begin
        hist_next = hist_reg;
        if (accept && (in_kind == gbp_pkg::KIND_UPDATE) && in_is_branch && in_is_cond)
        begin
            hist_next = HB'({hist_reg, in_was_taken});
        end
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_next = 1'b0;
        end
    end

    // buffer write: clearing or update at acceptance
    always_comb
    begin
        btb_wr = '0;
        if (clr_reg)
        begin
            btb_wr.en  = 1'b1;
            btb_wr.idx = clr_cnt_reg[IB-1:0];
        end
        else if (accept && (in_kind == gbp_pkg::KIND_UPDATE))
        begin
            btb_wr.en           = 1'b1;
            btb_wr.idx          = in_pc[IB+1:2];
            btb_wr.entry.vld    = in_is_branch;
            btb_wr.entry.cond   = in_is_cond;
            btb_wr.entry.tag    = in_pc;
            btb_wr.entry.target = in_target;
        end
    end

    assign pht_rd.en  = accept;
    assign pht_rd.idx = in_cidx;

    // saturating counter step
    always_comb
    begin
        cnt_upd = cnt;
        if (s1_taken_reg)
        begin
            if (cnt != gbp_pkg::CNT_MAX)
            begin
                cnt_upd = cnt + 2'd1;
            end
        end
        else if (cnt != gbp_pkg::CNT_MIN)
        begin
            cnt_upd = cnt - 2'd1;
        end
    end

    // counter write: clearing or read-modify-write from the working stage
    always_comb
    begin
        pht_wr = '0;
        if (clr_reg)
        begin
            pht_wr.en  = 1'b1;
            pht_wr.idx = clr_cnt_reg[HB-1:0];
        end
        else if (s1_vld_reg && s1_upd_cnt_reg)
        begin
            pht_wr.en  = 1'b1;
            pht_wr.idx = s1_cidx_reg;
            pht_wr.val = cnt_upd;
        end
    end

    // prediction from the read entry
    assign hit         = btb_entry.vld && (btb_entry.tag == s1_pc_reg);
    assign hit_cond    = hit && btb_entry.cond;
    assign pred_taken  = hit && (!btb_entry.cond || (cnt >= gbp_pkg::CNT_TAKEN_MIN));
    assign pred_target = hit ? btb_entry.target : '0;

    assign m_load = s1_vld_reg && (s1_kind_reg == gbp_pkg::KIND_PREDICT) && s1_adv;

    always_comb
    begin
        m_vld_next = m_vld_reg;
        if (m_load)
        begin
            m_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_vld_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            hist_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            hist_reg    <= hist_next;
            s1_vld_reg  <= s1_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg    <= in_kind;
            s1_pc_reg      <= in_pc;
            s1_upd_cnt_reg <= (in_kind == gbp_pkg::KIND_UPDATE) && in_is_branch && in_is_cond;
            s1_taken_reg   <= in_was_taken;
            s1_cidx_reg    <= in_cidx;
        end
        if (m_load)
        begin
            m_data_reg <= {5'd0, pred_target, pred_taken, hit_cond, hit};
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

    gbp_btb u_btb
    (
        .clk      (clk),
        .rd_en    (accept),
        .rd_idx   (in_pc[IB+1:2]),
        .wr       (btb_wr),
        .rd_entry (btb_entry)
    );

    gbp_pht u_pht
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (pht_rd),
        .wr    (pht_wr),
        .cnt   (cnt)
    );

    `GBP_ASSERT_NEVER(a_no_req_in_clear, clr_reg && s_axis_tready, "request taken during clearing")
    `GBP_ASSERT(a_upd_never_stalls, (s1_vld_reg && (s1_kind_reg == gbp_pkg::KIND_UPDATE) |-> s1_adv), "update stalled")
    `GBP_ASSERT(a_predict_held, (s1_vld_reg && !s1_adv |=> s1_vld_reg && $stable(s1_pc_reg)), "stalled predict lost")
    `GBP_ASSERT_NEVER(a_cnt_wr_in_predict, pht_wr.en && !clr_reg && (s1_kind_reg == gbp_pkg::KIND_PREDICT), "counter written by predict")

endmodule

// File: hdl/gbp_btb.sv
// Branch target buffer: direct-mapped entry memory with registered read.
module gbp_btb
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  gbp_pkg::bidx_t       rd_idx,
    input  gbp_pkg::btb_wr_t     wr,
    output gbp_pkg::btb_entry_t  rd_entry
);

    gbp_pkg::btb_entry_t mem [2**gbp_pkg::IDX_BITS];
    gbp_pkg::btb_entry_t rd_entry_reg;

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// File: hdl/gbp_pht.sv
// Direction counter memory with bypass of the most recent write.
module gbp_pht
(
    input  logic              clk,
    input  logic              rst_n,
    input  gbp_pkg::pht_rd_t  rd,
    input  gbp_pkg::pht_wr_t  wr,
    output logic [1:0]        cnt
);

    logic [1:0]     mem [2**gbp_pkg::HIST_BITS];
    logic [1:0]     rd_data_reg;
    gbp_pkg::cidx_t rd_idx_reg;
    logic           fwd_vld_reg;
    gbp_pkg::cidx_t fwd_idx_reg;
    logic [1:0]     fwd_val_reg;

    // memory: a read sees writes of earlier edges only
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.val;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.idx];
            rd_idx_reg  <= rd.idx;
        end
    end

    // last write, it always matches memory content at its index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 1'b0;
        end
        else if (wr.en)
        begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fwd_idx_reg <= wr.idx;
            fwd_val_reg <= wr.val;
        end
    end

    // covers the write that landed on the same edge as the read
    assign cnt = (fwd_vld_reg && (fwd_idx_reg == rd_idx_reg)) ? fwd_val_reg : rd_data_reg;

endmodule

// File: verif/gshare_branch_predictor_btb_checker.sv
// Checker for the branch predictor: tracks buffer and counter state, compares every lookup result.
module gshare_branch_predictor_btb_checker
    import gbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_tvalid,
    input  logic        req_tready,
    input  logic [71:0] req_tdata,
    input  logic        req_tuser,
    input  logic        rsp_tvalid,
    input  logic        rsp_tready,
    input  logic [39:0] rsp_tdata,
    output int          mismatches,
    output int          pending,
    output int          lookups,
    output int          lookup_hits,
    output int          taken_hits,
    output int          updates
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNTERS   = 1 << HIST_BITS;
    localparam int SLOTS      = 1 << IDX_BITS;
    localparam int REPORT_MAX = 40;

    typedef struct {
        logic            hit;
        logic            cond;
        logic            taken;
        logic [PC_W-1:0] target;
    } lookup_result_t;

    // local copy of the predictor state
    logic [1:0]      pattern_ctr [COUNTERS];
    cidx_t           path_history;
    logic            slot_valid  [SLOTS];
    logic            slot_cond   [SLOTS];
    logic [PC_W-1:0] slot_tag    [SLOTS];
    logic [PC_W-1:0] slot_target [SLOTS];

    // lookups accepted but not yet answered, oldest first
    lookup_result_t  awaited_lookups [$];
    int              results_seen;

    task automatic report_mismatch(input string what, input logic [PC_W-1:0] got,
                                   input logic [PC_W-1:0] want);
        if (mismatches < REPORT_MAX)
            $display("%0t ns: result %0d %s: got %0h, expected %0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // sample both channels at the rising edge; requests first, then results
    always @(posedge clk)
    begin : watch
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] tgt;
        logic            br;
        logic            cond;
        logic            taken;
        bidx_t           bi;
        cidx_t           ci;
        lookup_result_t  res;
        if (!rst_n)
        begin
            for (int i = 0; i < COUNTERS; i++)
                pattern_ctr[i] = CNT_MIN;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i]  = 1'b0;
                slot_cond[i]   = 1'b0;
                slot_tag[i]    = '0;
                slot_target[i] = '0;
            end
            path_history = '0;
            awaited_lookups.delete();
            results_seen = 0;
            mismatches   = 0;
            pending      = 0;
            lookups      = 0;
            lookup_hits  = 0;
            taken_hits   = 0;
            updates      = 0;
        end
        else
        begin
            if (req_tvalid && req_tready)
            begin
                pc    = req_tdata[31:0];
                br    = req_tdata[32];
                cond  = req_tdata[33];
                taken = req_tdata[34];
                tgt   = req_tdata[66:35];
                bi    = pc[IDX_BITS+1:2];
                ci    = pc[HIST_BITS+1:2] ^ path_history;
                if (req_tuser == KIND_PREDICT)
                begin
                    // lookup: full tag must match a valid slot
                    res = '{default: '0};
                    if (slot_valid[bi] && slot_tag[bi] == pc)
                    begin
                        res.hit    = 1'b1;
                        res.cond   = slot_cond[bi];
                        res.target = slot_target[bi];
                        res.taken  = slot_cond[bi] ? (pattern_ctr[ci] >= CNT_TAKEN_MIN) : 1'b1;
                        lookup_hits++;
                        if (res.taken)
                            taken_hits++;
                    end
                    awaited_lookups.push_back(res);
                    lookups++;
                end
                else
                begin
                    updates++;
                    if (!br)
                        slot_valid[bi] = 1'b0;
                    else
                    begin
                        slot_valid[bi]  = 1'b1;
                        slot_cond[bi]   = cond;
                        slot_tag[bi]    = pc;
                        slot_target[bi] = tgt;
                        // only conditional branches train the counters and history
                        if (cond)
                        begin
                            if (taken && pattern_ctr[ci] != CNT_MAX)
                                pattern_ctr[ci]++;
                            else if (!taken && pattern_ctr[ci] != CNT_MIN)
                                pattern_ctr[ci]--;
                            path_history = {path_history[HIST_BITS-2:0], taken};
                        end
                    end
                end
            end

            if (rsp_tvalid && rsp_tready)
            begin
                if (awaited_lookups.size() == 0)
                    report_mismatch("arrived with no lookup waiting, target",
                                    rsp_tdata[34:3], '0);
                else
                begin
                    res = awaited_lookups.pop_front();
                    if (rsp_tdata[0] !== res.hit)
                        report_mismatch("hit_branch", PC_W'(rsp_tdata[0]), PC_W'(res.hit));
                    if (rsp_tdata[1] !== res.cond)
                        report_mismatch("hit_conditional", PC_W'(rsp_tdata[1]),
                                        PC_W'(res.cond));
                    if (rsp_tdata[2] !== res.taken)
                        report_mismatch("predict_taken", PC_W'(rsp_tdata[2]),
                                        PC_W'(res.taken));
                    if (rsp_tdata[34:3] !== res.target)
                        report_mismatch("predict_target", rsp_tdata[34:3], res.target);
                end
                results_seen++;
            end
            pending = awaited_lookups.size();
        end
    end

endmodule

// File: verif/gshare_branch_predictor_btb_unit_tb.sv
// Testbench top for the branch predictor: clock, reset, request stimulus and verdict.
module gshare_branch_predictor_btb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 75;
    localparam int POOL_SIZE    = 16;
    localparam int ALIAS_COUNT  = 4;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_done      = 1'b0;
    int   cycle_count    = 0;

    int mismatches;
    int pending;
    int lookups;
    int lookup_hits;
    int taken_hits;
    int updates;

    // addresses reused so that lookups hit; the last few alias earlier ones
    logic [PC_W-1:0] pc_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gshare_branch_predictor_btb_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gshare_branch_predictor_btb_checker prediction_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_tvalid  (s_axis_tvalid),
        .req_tready  (s_axis_tready),
        .req_tdata   (s_axis_tdata),
        .req_tuser   (s_axis_tuser),
        .rsp_tvalid  (m_axis_tvalid),
        .rsp_tready  (m_axis_tready),
        .rsp_tdata   (m_axis_tdata),
        .mismatches  (mismatches),
        .pending     (pending),
        .lookups     (lookups),
        .lookup_hits (lookup_hits),
        .taken_hits  (taken_hits),
        .updates     (updates)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL gshare_branch_predictor_btb_unit");
            $finish;
        end
    end

    // result sink: random stalls, plus one long hold-off on request
    initial
    begin : sink
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one request and wait for its handshake; called and left at a falling edge
    task automatic send_request(input logic kind, input logic [PC_W-1:0] pc,
                                input logic br, input logic cond, input logic taken,
                                input logic [PC_W-1:0] tgt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, tgt, taken, cond, br, pc};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // random mix of lookups and updates, mostly on pooled addresses
    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        logic [PC_W-1:0] pc;
        logic            kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            pc   = ($urandom_range(99) < 85) ? pc_pool[$urandom_range(POOL_SIZE-1)]
                                             : $urandom();
            kind = ($urandom_range(1) == 0) ? KIND_PREDICT : KIND_UPDATE;
            send_request(kind, pc, $urandom_range(99) < 85, $urandom_range(99) < 70,
                         1'($urandom_range(1)), $urandom());
        end
    endtask

    initial
    begin : stimulus
        for (int i = 0; i < POOL_SIZE - ALIAS_COUNT; i++)
            pc_pool[i] = $urandom();
        // same buffer index, different tag
        for (int i = POOL_SIZE - ALIAS_COUNT; i < POOL_SIZE; i++)
            pc_pool[i] = pc_pool[i - (POOL_SIZE - ALIAS_COUNT)]
                         ^ {20'($urandom_range(20'hFFFFF, 1)), 12'h000};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty buffer, extremes, aliasing, clearing, saturation
        send_request(KIND_PREDICT, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'hDEAD_BEEF);
        send_request(KIND_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        send_request(KIND_UPDATE,  32'h0000_0010, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(KIND_PREDICT, 32'h0000_0010, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        send_request(KIND_UPDATE,  32'hFFFF_FFFC, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        send_request(KIND_PREDICT, 32'hFFFF_FFFC, 1'b1, 1'b1, 1'b1, 32'h1234_5678);
        send_request(KIND_PREDICT, 32'h0000_0FFC, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        // non-branch update with conditional and taken set: clears only
        send_request(KIND_UPDATE,  32'hFFFF_FFFC, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(KIND_PREDICT, 32'hFFFF_FFFC, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        // history saturates at all ones, then the counter at that index climbs to its maximum
        repeat (10)
            send_request(KIND_UPDATE, 32'h0000_0020, 1'b1, 1'b1, 1'b1, 32'h0000_0040);
        send_request(KIND_PREDICT, 32'h0000_0020, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        repeat (4)
            send_request(KIND_UPDATE, 32'h0000_0020, 1'b1, 1'b1, 1'b0, 32'h0000_0080);
        send_request(KIND_PREDICT, 32'h0000_0020, 1'b1, 1'b0, 1'b1, 32'h0000_0000);

        // random phases with different idling on each side
        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 67, 0);
        run_phase(PHASE_ITEMS, 0, 67);
        run_phase(PHASE_ITEMS, 21, 21);
        // sink holds off while requests keep coming, so the block backs up
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests: %0d lookups (%0d hits, %0d predicted taken), %0d updates.",
                 lookups + updates, lookups, lookup_hits, taken_hits, updates);
        $display("Idling phases on both sides and a %0d-cycle result hold-off were exercised.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS gshare_branch_predictor_btb_unit");
        else
            $display("FAIL gshare_branch_predictor_btb_unit");
        $finish;
    end

endmodule
